### hdl/texture_twiddle_address_gen_top_macros.svh
// ----------------------------------------------------------------------------
// texture twiddle address generator assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef TEXTURE_TWIDDLE_ADDRESS_GEN_TOP_MACROS_SVH
`define TEXTURE_TWIDDLE_ADDRESS_GEN_TOP_MACROS_SVH

// checked outside reset only
`define TTAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TTAG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ttag_pkg.sv
// ----------------------------------------------------------------------------
// ttag_pkg
// shared widths, register codes and types of the twiddle address generator
// ----------------------------------------------------------------------------
package ttag_pkg;

  localparam int MAX_SIDE_LOG2 = 10;
  localparam int PIXEL_BITS    = 16;

  localparam int CNT_W = MAX_SIDE_LOG2;
  localparam int IDX_W = 2 * MAX_SIDE_LOG2;
  localparam int LOG_W = 4;
  localparam int PIX_W = 16;

  localparam logic [LOG_W-1:0] LOG2_MAX   = LOG_W'(MAX_SIDE_LOG2);
  localparam logic [LOG_W-1:0] LOG2_RESET = LOG_W'(3);

  // configuration register indexes
  localparam logic REG_WIDTH_LOG2  = 1'b0;
  localparam logic REG_HEIGHT_LOG2 = 1'b1;

  // pixel mask for narrower pixel configurations
  localparam logic [PIX_W-1:0] PIX_MASK =
    (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << PIXEL_BITS) - 1);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             last;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_next;
  } ttag_step_t;

endpackage

### hdl/texture_twiddle_address_gen_top.sv
// ----------------------------------------------------------------------------
// texture_twiddle_address_gen_top
// pairs raster-order texture pixels with their twiddled element index
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on in_valid/in_ready/pixel_in in raster order, one item per
//   pixel. each item comes back on out_valid/out_ready with twiddled_index,
//   pixel_out and last_of_image, which marks the final pixel of the texture.
//   width_log2 and height_log2 are set through cfg_write/cfg_index/cfg_data
//   while no item is in flight; values above 10 saturate to 10.
//   out_valid rises in the cycle after acceptance. throughput is one item
//   per cycle: the index is formed from the column and row counters in one
//   combinational pass into the result register, and in_ready stays high
//   while that register is empty or being taken.
//   when the receiver stalls, the result register holds and in_ready drops
//   until the item is taken.
//   reset clears the counters and out_valid (not the result payload) and sets both log2
//   registers to 3 (an 8x8 texture). counters wrap to zero after the last
//   pixel.
// ----------------------------------------------------------------------------
`include "texture_twiddle_address_gen_top_macros.svh"

module texture_twiddle_address_gen_top
  import ttag_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] twiddled_index,
  output logic [PIX_W-1:0] pixel_out,
  output logic             last_of_image,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [LOG_W-1:0] cfg_data
);

  logic [LOG_W-1:0] width_log2, height_log2;
  logic [CNT_W-1:0] column_count, row_count;
  ttag_step_t       step;
  logic             accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  ttag_index u_index (
    .column_count (column_count),
    .row_count    (row_count),
    .width_log2   (width_log2),
    .height_log2  (height_log2),
    .step         (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2  <= LOG2_RESET;
      height_log2 <= LOG2_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH_LOG2:  width_log2  <= cfg_data;
        REG_HEIGHT_LOG2: height_log2 <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= step.col_next;
        row_count    <= step.row_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      twiddled_index <= step.index;
      pixel_out      <= pixel_in & PIX_MASK;
      last_of_image  <= step.last;
    end
  end

  `TTAG_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && column_count == '0 && row_count == '0, "reset did not clear counters and result")
  `TTAG_ASSERT(a_accept_fills, accept |=> out_valid, "accepted item gave no result")
  `TTAG_ASSERT(a_last_wraps, accept && step.last |=> column_count == '0 && row_count == '0, "counters did not wrap after last pixel")
  `TTAG_ASSERT(a_idle_holds, !accept |=> $stable(column_count) && $stable(row_count), "counters moved without an item")

endmodule

### hdl/ttag_index.sv
// ----------------------------------------------------------------------------
// ttag_index
// morton index of the current raster position and the next counter values
// ----------------------------------------------------------------------------
module ttag_index
  import ttag_pkg::*;
(
  input  logic [CNT_W-1:0] column_count,
  input  logic [CNT_W-1:0] row_count,
  input  logic [LOG_W-1:0] width_log2,
  input  logic [LOG_W-1:0] height_log2,
  output ttag_step_t       step
);

  logic [LOG_W-1:0] wl, hl, ml;
  logic [CNT_W:0]   wspan, hspan, tspan;
  logic [CNT_W-1:0] wmax, hmax, tmask;
  logic [CNT_W-1:0] col, row, col_t, row_t;
  logic [CNT_W:0]   tile;
  logic [IDX_W-1:0] inter, tile_sh;
  logic             last_col;

  // log2 values above range saturate
  assign wl = (width_log2  > LOG2_MAX) ? LOG2_MAX : width_log2;
  assign hl = (height_log2 > LOG2_MAX) ? LOG2_MAX : height_log2;
  assign ml = (wl < hl) ? wl : hl;

  assign wspan = (CNT_W+1)'(1) << wl;
  assign hspan = (CNT_W+1)'(1) << hl;
  assign tspan = (CNT_W+1)'(1) << ml;
  assign wmax  = CNT_W'(wspan - (CNT_W+1)'(1));
  assign hmax  = CNT_W'(hspan - (CNT_W+1)'(1));
  assign tmask = CNT_W'(tspan - (CNT_W+1)'(1));

  // counters may exceed a newly written size, keep only the low bits
  assign col   = column_count & wmax;
  assign row   = row_count & hmax;
  assign col_t = col & tmask;
  assign row_t = row & tmask;

  // row bits on even positions, column bits on odd positions
  always_comb begin
    inter = '0;
    for (int i = 0; i < CNT_W; i++) begin
      inter[2*i]   = row_t[i];
      inter[2*i+1] = col_t[i];
    end
  end

  assign tile    = (CNT_W+1)'(col >> ml) + (CNT_W+1)'(row >> ml);
  assign tile_sh = IDX_W'(tile) << {ml, 1'b0};

  assign last_col = (col == wmax);

  always_comb begin
    step.index = inter + tile_sh;
    step.last  = last_col && (row == hmax);
    if (last_col) begin
      step.col_next = '0;
      step.row_next = step.last ? '0 : row + CNT_W'(1);
    end else begin
      step.col_next = col + CNT_W'(1);
      step.row_next = row;
    end
  end

endmodule
